[src/xsbd_pkg.sv]
// xsbd_pkg: constants, types and combinational helpers for the bounded
// xoshiro256** draw block. No dependencies.
`timescale 1ns / 1ps

package xsbd_pkg;

    // splitmix64 seeding constants
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;

    // draw kinds carried on tuser
    localparam logic OP_RAW     = 1'b0;
    localparam logic OP_BOUNDED = 1'b1;

    // configuration register map
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] SEED_ADDR = 3'h0;

    // sequencer limits
    localparam int unsigned DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd63;
    localparam logic [1:0] MUL_LAST  = 2'd2;
    localparam logic [1:0] WORD_LAST = 2'd3;

    typedef logic [3:0][63:0] xsbd_gen_t;

    typedef enum logic [3:0] {
        ST_SEED_ADD,
        ST_SEED_MUL,
        ST_SEED_MIX,
        ST_SEED_STORE,
        ST_IDLE,
        ST_FLOOR,
        ST_DRAW,
        ST_CHECK,
        ST_REM,
        ST_DONE
    } xsbd_state_t;

    // xoshiro256** scrambled output: rotl(w1 * 5, 7) * 9
    function automatic logic [63:0] xsbd_outv(input xsbd_gen_t w);
        logic [63:0] t;
        logic [63:0] r;
        t = w[1] + {w[1][61:0], 2'b00};
        r = {t[56:0], t[63:57]};
        return r + {r[60:0], 3'b000};
    endfunction

    // one xoshiro256 state transition
    function automatic xsbd_gen_t xsbd_advance(input xsbd_gen_t w);
        xsbd_gen_t   n;
        logic [63:0] sh;
        sh   = {w[1][46:0], 17'd0};
        n    = w;
        n[2] = w[2] ^ w[0];
        n[3] = w[3] ^ w[1];
        n[1] = w[1] ^ n[2];
        n[0] = w[0] ^ n[3];
        n[2] = n[2] ^ sh;
        n[3] = {n[3][18:0], n[3][63:19]};
        return n;
    endfunction

endpackage

[src/xoshiro256ss_bounded_draw_top.sv]
// xoshiro256ss_bounded_draw_top: xoshiro256** generator with splitmix64 seeding
// and an unbiased bounded draw. Depends on xsbd_pkg.
// Raw draw or bound under two: the result is held in ST_DONE and goes on to the output register
// once that register is free.
// Bounded draw: 2*64 remainder steps of the shared bit-serial divider (floor, then result) plus
// ST_DRAW and ST_CHECK per raw output drawn; outputs under the floor are rejected and redrawn.
// One word in flight; the next is taken once the result is handed to the output register.
// Reset and every seed write run a 4-word splitmix64 fill through
// the shared 32x32 multiplier; no word is accepted meanwhile.
`timescale 1ns / 1ps

module xoshiro256ss_bounded_draw_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [xsbd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [63:0]                         pwdata,
    output logic [63:0]                         prdata,
    output logic                                pready,
    // draw requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // [31:0] bound
    input  logic                                s_tuser,   // [0] op
    // draw results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata    // [63:0] value
);
    import xsbd_pkg::*;

    xsbd_state_t          state_reg, state_next;
    logic [63:0]          seed_reg, seed_next;
    logic [63:0]          ctr_reg, ctr_next;
    xsbd_gen_t            gen_reg, gen_next;
    logic [1:0]           idx_reg, idx_next;
    logic [1:0]           mcnt_reg, mcnt_next;
    logic                 mpass_reg, mpass_next;
    logic [63:0]          mopnd_reg, mopnd_next;
    logic [63:0]          acc_reg, acc_next;
    logic                 op_reg, op_next;
    logic [31:0]          bound_reg, bound_next;
    logic [31:0]          rem_reg, rem_next;
    logic [63:0]          dvd_reg, dvd_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [31:0]          floor_reg, floor_next;
    logic [63:0]          r_reg, r_next;
    logic [63:0]          res_reg, res_next;
    logic                 mvalid_reg, mvalid_next;
    logic [63:0]          mdata_reg, mdata_next;

    logic                 seed_wr;
    logic                 in_acc;
    xsbd_gen_t            gen_adv;
    logic [63:0]          draw_out;
    // shared multiplier
    logic [63:0]          mul_c;
    logic [31:0]          mul_x, mul_y;
    logic [63:0]          mul_p;
    logic [63:0]          mul_add;
    // shared remainder step
    logic [32:0]          div_t;
    logic [32:0]          div_d;
    logic [31:0]          rem_step;

    assign pready   = 1'b1;
    assign prdata   = (paddr == SEED_ADDR) ? seed_reg : 64'd0;
    assign seed_wr  = psel && penable && pwrite && pready && (paddr == SEED_ADDR);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    assign gen_adv  = xsbd_advance(gen_reg);
    assign draw_out = xsbd_outv(gen_reg);

    // 64x64 low product over three passes: lo*lo, lo*hi, hi*lo
    assign mul_c   = mpass_reg ? MIX_MUL_B : MIX_MUL_A;
    assign mul_x   = (mcnt_reg == MUL_LAST) ? mopnd_reg[63:32] : mopnd_reg[31:0];
    assign mul_y   = (mcnt_reg == 2'd1) ? mul_c[63:32] : mul_c[31:0];
    assign mul_p   = 64'(mul_x) * 64'(mul_y);
    assign mul_add = (mcnt_reg == 2'd0) ? mul_p : {mul_p[31:0], 32'd0};

    // restoring remainder, one dividend bit per cycle; borrow means keep the shifted value
    assign div_t    = {rem_reg, dvd_reg[63]};
    assign div_d    = div_t - {1'b0, bound_reg};
    assign rem_step = div_d[32] ? div_t[31:0] : div_d[31:0];

    always_comb begin
        state_next  = state_reg;
        seed_next   = seed_reg;
        ctr_next    = ctr_reg;
        gen_next    = gen_reg;
        idx_next    = idx_reg;
        mcnt_next   = mcnt_reg;
        mpass_next  = mpass_reg;
        mopnd_next  = mopnd_reg;
        acc_next    = acc_reg;
        op_next     = op_reg;
        bound_next  = bound_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dcnt_next   = dcnt_reg;
        floor_next  = floor_reg;
        r_next      = r_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_SEED_ADD: begin
                ctr_next   = ctr_reg + GOLDEN_GAMMA;
                mopnd_next = ctr_next ^ (ctr_next >> 30);
                mpass_next = 1'b0;
                mcnt_next  = 2'd0;
                state_next = ST_SEED_MUL;
            end
            ST_SEED_MUL: begin
                acc_next  = ((mcnt_reg == 2'd0) ? 64'd0 : acc_reg) + mul_add;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == MUL_LAST) begin
                    state_next = mpass_reg ? ST_SEED_STORE : ST_SEED_MIX;
                end
            end
            ST_SEED_MIX: begin
                mopnd_next = acc_reg ^ (acc_reg >> 27);
                mpass_next = 1'b1;
                mcnt_next  = 2'd0;
                state_next = ST_SEED_MUL;
            end
            ST_SEED_STORE: begin
                gen_next[idx_reg] = acc_reg ^ (acc_reg >> 31);
                idx_next          = idx_reg + 2'd1;
                state_next        = (idx_reg == WORD_LAST) ? ST_IDLE : ST_SEED_ADD;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    op_next    = s_tuser;
                    bound_next = s_tdata;
                    if (s_tuser == OP_RAW) begin
                        gen_next   = gen_adv;
                        res_next   = draw_out;
                        state_next = ST_DONE;
                    end else if (s_tdata < 32'd2) begin
                        res_next   = 64'd0;
                        state_next = ST_DONE;
                    end else begin
                        // 2^64 - bound, reduced below to 2^64 mod bound
                        dvd_next   = 64'd0 - {32'd0, s_tdata};
                        rem_next   = 32'd0;
                        dcnt_next  = '0;
                        state_next = ST_FLOOR;
                    end
                end
            end
            ST_FLOOR: begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[62:0], 1'b0};
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_LAST) begin
                    floor_next = rem_step;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                gen_next   = gen_adv;
                r_next     = draw_out;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // reject outputs under the floor and draw again
                if (r_reg >= {32'd0, floor_reg}) begin
                    dvd_next   = r_reg;
                    rem_next   = 32'd0;
                    dcnt_next  = '0;
                    state_next = ST_REM;
                end else begin
                    state_next = ST_DRAW;
                end
            end
            ST_REM: begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[62:0], 1'b0};
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_LAST) begin
                    res_next   = {32'd0, rem_step};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = res_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a seed write restarts the splitmix64 fill
        if (seed_wr) begin
            seed_next  = pwdata;
            ctr_next   = pwdata;
            idx_next   = 2'd0;
            state_next = ST_SEED_ADD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SEED_ADD;
            seed_reg   <= 64'd0;
            ctr_reg    <= 64'd0;
            idx_reg    <= 2'd0;
            mcnt_reg   <= 2'd0;
            mpass_reg  <= 1'b0;
            dcnt_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            seed_reg   <= seed_next;
            ctr_reg    <= ctr_next;
            idx_reg    <= idx_next;
            mcnt_reg   <= mcnt_next;
            mpass_reg  <= mpass_next;
            dcnt_reg   <= dcnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gen_reg   <= gen_next;
        mopnd_reg <= mopnd_next;
        acc_reg   <= acc_next;
        op_reg    <= op_next;
        bound_reg <= bound_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        floor_reg <= floor_next;
        r_reg     <= r_next;
        res_reg   <= res_next;
        mdata_reg <= mdata_next;
    end

    // a seed write blocks new requests while the fill runs
    a_seed_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_wr |=> !s_tready)
        else $error("request accepted right after seed write");

    // partial remainder stays below the divisor
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLOOR || state_reg == ST_REM) |-> (rem_reg < bound_reg))
        else $error("partial remainder not below bound");

    // rejection floor is below the bound
    a_floor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW || state_reg == ST_CHECK) |-> (floor_reg < bound_reg))
        else $error("rejection floor not below bound");

    // a bounded result lies below its bound
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && op_reg == OP_BOUNDED && bound_reg >= 32'd2)
            |-> (res_reg < {32'd0, bound_reg}))
        else $error("bounded result not below bound");

endmodule
